[rtl/mks_pkg.sv]
`timescale 1ns / 1ps
// mks_pkg: shared types and constants for the 4x4 keypad scanner.
// No dependencies; imported by every module under rtl/.
package mks_pkg;

	localparam int NIBBLE_W = 4;
	localparam int KEY_W    = 5;
	localparam int PHASE_W  = 2;

	localparam logic [NIBBLE_W-1:0]   NIBBLE_NONE = 4'hF;
	localparam logic [2*NIBBLE_W-1:0] BYTE_NONE   = 8'hFF;

	// reported phase codes
	localparam logic [PHASE_W-1:0] PH_CODE_IDLE    = 2'd0;
	localparam logic [PHASE_W-1:0] PH_CODE_DECODE  = 2'd1;
	localparam logic [PHASE_W-1:0] PH_CODE_RELEASE = 2'd2;

	localparam int                 KEY_COUNT = 16;
	localparam logic [KEY_W-1:0]   KEY_BASE  = 5'd4;

	// merged byte (col high nibble, row low nibble) for keys 4..19
	localparam logic [7:0] KEY_CODE [KEY_COUNT] = '{
		8'h77, 8'h7B, 8'h7D, 8'h7E,
		8'hB7, 8'hBB, 8'hBD, 8'hBE,
		8'hD7, 8'hDB, 8'hDD, 8'hDE,
		8'hE7, 8'hEB, 8'hED, 8'hEE
	};

	typedef enum logic [2:0] {
		PH_IDLE    = 3'b001,
		PH_DECODE  = 3'b010,
		PH_RELEASE = 3'b100
	} phase_t;

	typedef struct packed {
		logic [KEY_W-1:0]   key_number;
		logic               key_done;
		logic [PHASE_W-1:0] scan_phase;
	} result_t;

	function automatic logic [PHASE_W-1:0] phase_code(input phase_t ph);
		logic [PHASE_W-1:0] c;
		unique case (ph)
			PH_DECODE:  c = PH_CODE_DECODE;
			PH_RELEASE: c = PH_CODE_RELEASE;
			default:    c = PH_CODE_IDLE;
		endcase
		return c;
	endfunction

endpackage

[rtl/mks_key_decode.sv]
`timescale 1ns / 1ps
// mks_key_decode: maps a merged line byte to a key number.
// Depends on mks_pkg (KEY_CODE table).
module mks_key_decode import mks_pkg::*; (
	input  logic [2*NIBBLE_W-1:0] merged,
	output logic                  hit,
	output logic [KEY_W-1:0]      key_num
);

	// table entries are distinct, so at most one compare fires
	always_comb begin
		hit     = 1'b0;
		key_num = '0;
		for (int i = 0; i < KEY_COUNT; i++) begin
			if (merged == KEY_CODE[i]) begin
				hit     = 1'b1;
				key_num = KEY_BASE + KEY_W'(i);
			end
		end
	end

endmodule

[rtl/mks_scan_step.sv]
`timescale 1ns / 1ps
// mks_scan_step: scanner phase and key registers with next-state logic.
// Depends on mks_pkg and mks_key_decode.
module mks_scan_step import mks_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step_en,
	input  logic [NIBBLE_W-1:0] row_sense,
	input  logic [NIBBLE_W-1:0] col_sense,
	output result_t             result
);

	phase_t            phase_q, phase_d;
	logic [KEY_W-1:0]  key_q, key_d;
	logic              done_d;
	logic              hit;
	logic [KEY_W-1:0]  key_num;
	logic [2*NIBBLE_W-1:0] merged;

	assign merged = {col_sense, row_sense};

	mks_key_decode u_decode (
		.merged  (merged),
		.hit     (hit),
		.key_num (key_num)
	);

	always_comb begin
		phase_d = phase_q;
		key_d   = key_q;
		done_d  = 1'b0;
		unique case (phase_q)
			PH_DECODE: begin
				if (merged != BYTE_NONE) begin
					if (hit) begin
						key_d = key_num;
					end
					phase_d = PH_RELEASE;
				end
			end
			PH_RELEASE: begin
				if (row_sense == NIBBLE_NONE) begin
					phase_d = PH_IDLE;
					done_d  = 1'b1;
				end
			end
			default: begin
				phase_d = (row_sense != NIBBLE_NONE) ? PH_DECODE : PH_IDLE;
			end
		endcase
	end

	assign result = '{key_number: key_d, key_done: done_d, scan_phase: phase_code(phase_d)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			key_q   <= '0;
		end else if (step_en) begin
			phase_q <= phase_d;
			key_q   <= key_d;
		end
	end

endmodule

[rtl/mks_out_skid.sv]
`timescale 1ns / 1ps
// mks_out_skid: two-entry output register with skid slot for result requests.
// Depends on mks_pkg (result_t).
module mks_out_skid import mks_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	output logic    full,
	output logic    out_valid,
	input  logic    out_stall,
	output result_t out_data
);

	logic    main_v_q, skid_v_q;
	result_t main_q, skid_q;
	logic    pop;

	assign pop       = main_v_q && !out_stall;
	assign out_valid = main_v_q;
	assign out_data  = main_q;
	assign full      = skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			// no push possible while skid is occupied
			if (pop) begin
				skid_v_q <= 1'b0;
			end
		end else if (push) begin
			if (main_v_q && !pop) begin
				skid_v_q <= 1'b1;
			end else begin
				main_v_q <= 1'b1;
			end
		end else if (pop) begin
			main_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (pop) begin
				main_q <= skid_q;
			end
		end else if (push) begin
			if (main_v_q && !pop) begin
				skid_q <= push_data;
			end else begin
				main_q <= push_data;
			end
		end
	end

endmodule

[rtl/matrix_keypad_scanner.sv]
`timescale 1ns / 1ps
// matrix_keypad_scanner: top level of the 4x4 keypad scanner.
// Depends on mks_pkg, mks_scan_step, mks_key_decode and mks_out_skid.
//
//  channel | handshake             | payload
//  --------+-----------------------+------------------------------------
//  in      | in_valid / in_stall   | row_sense[3:0], col_sense[3:0]
//  out     | out_valid / out_stall | key_number[4:0], key_done, scan_phase[1:0]
//
// One scan tick per cycle while in_stall is low: a request is stepped
// through the phase logic in the cycle it is accepted and its result is
// registered in the output stage (main register, or skid slot while main
// is held). Reset (arst_n low) returns the scanner to idle with key number
// zero and empties the output stage. in_stall rises only once the two-entry
// output stage is full; it is taken straight from a register.
module matrix_keypad_scanner import mks_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [NIBBLE_W-1:0] row_sense,
	input  logic [NIBBLE_W-1:0] col_sense,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [KEY_W-1:0]    key_number,
	output logic                key_done,
	output logic [PHASE_W-1:0]  scan_phase
);

	logic    accept;
	logic    buf_full;
	result_t step_res;
	result_t out_res;

	// a request is taken whenever the output stage has a free slot
	assign in_stall = buf_full;
	assign accept   = in_valid && !buf_full;

	// phase/key state advances only on an accepted tick
	mks_scan_step u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (accept),
		.row_sense (row_sense),
		.col_sense (col_sense),
		.result    (step_res)
	);

	mks_out_skid u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (step_res),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_res)
	);

	assign key_number = out_res.key_number;
	assign key_done   = out_res.key_done;
	assign scan_phase = out_res.scan_phase;

	// a release pulse always leaves the scanner idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && key_done |-> scan_phase == PH_CODE_IDLE)
		else $error("key_done with scanner not idle");

	// the skid slot is only ever filled behind a full main register
	a_skid_order: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("skid occupied with empty output register");

	// key number is zero or a table key
	a_key_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (key_number == '0) || (key_number >= KEY_BASE && key_number <= 5'd19))
		else $error("key number out of range");

	// a stalled output holding a request does not lose it next cycle
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("stalled result dropped");

endmodule
